// ===== rtl/core/sfcs_pkg.sv =====
package sfcs_pkg;

  localparam int ADDR_W = 24;
  localparam int LEN_W = 25;
  localparam int QUEUE_DEPTH = 4;

  // Flash page size. It is a power of two, so the page offset is the low
  // address bits.
  localparam int PAGE_BYTES = 256;

  // Input operation codes.
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_WDATA   = 2'd1;
  localparam logic [1:0] OP_RX      = 2'd2;

  // Host request codes.
  localparam logic [2:0] CMD_IDENT = 3'd0;
  localparam logic [2:0] CMD_FETCH = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_ERASE = 3'd3;
  localparam logic [2:0] CMD_WAIT  = 3'd4;

  // Flash opcodes and filler.
  localparam logic [7:0] FL_WREN   = 8'h06;
  localparam logic [7:0] FL_RDSR   = 8'h05;
  localparam logic [7:0] FL_READ   = 8'h03;
  localparam logic [7:0] FL_PROG   = 8'h02;
  localparam logic [7:0] FL_SE     = 8'h20;
  localparam logic [7:0] FL_RDID   = 8'h9F;
  localparam logic [7:0] FL_DUMMY  = 8'hFF;

  // Job kinds handed from the front end to the back end.
  localparam logic [3:0] K_DONE      = 4'd0;
  localparam logic [3:0] K_ID_REQ    = 4'd1;
  localparam logic [3:0] K_READ_HDR  = 4'd2;
  localparam logic [3:0] K_PAGE      = 4'd3;
  localparam logic [3:0] K_ERASE     = 4'd4;
  localparam logic [3:0] K_POLL      = 4'd5;
  localparam logic [3:0] K_WBYTE     = 4'd6;
  localparam logic [3:0] K_ID_RES    = 4'd7;
  localparam logic [3:0] K_READ_DATA = 4'd8;

  typedef struct packed {
    logic [1:0]        op;
    logic [2:0]        command;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
    logic [7:0]        data_byte;
  } item_t;

  typedef struct packed {
    logic              tx_valid;
    logic [7:0]        tx_byte;
    logic              frame_start;
    logic              frame_end;
    logic              host_valid;
    logic [7:0]        host_byte;
    logic              id_valid;
    logic [ADDR_W-1:0] flash_identity;
    logic              done_res;
    logic              last;
  } result_t;

  // One job: the back end expands it into one to five result transactions.
  typedef struct packed {
    logic [3:0]        kind;
    logic [7:0]        data;
    logic [ADDR_W-1:0] value;
    logic              flag_a;
    logic              flag_b;
  } job_t;

endpackage

// ===== rtl/core/spi_flash_command_sequencer.sv =====
// Serial NOR flash command sequencer, master side of the link.
// Input channel (item_valid / item_stall / item): each transaction is a host
// request, a write data byte, or the byte received for one byte sent. One
// input transaction yields zero to five result transactions.
// Output channel (result_valid / result_stall / result): transmit bytes with
// chip-select frame marks, read data for the host, the identity word, the
// done mark, and a last flag on the final result of each input transaction.
// The job of an accepted transaction is written into the queue, and its first
// result then into the output register. The front end accepts one
// transaction per cycle while its four-entry job queue has room; the back
// end emits one result per cycle while the receiver does not stall.
// Reset (rst, synchronous) returns the sequencer to idle with no bytes in
// flight and empties the queue and output register.
// When the receiver stalls, the output register holds its result, the queue
// fills, and then item_stall rises until the back end drains a job.
module spi_flash_command_sequencer import sfcs_pkg::*; #(
  parameter int SECTOR_MASK  = 4095,
  parameter int ADDRESS_BITS = 24
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t head;

  // Front end: tracks the flash protocol state and turns each input
  // transaction into at most one job.
  sfcs_front #(
    .SECTOR_MASK  (SECTOR_MASK),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  // Short job queue so the two halves stall independently.
  sfcs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  // Back end: expands each job into result transactions, one per unstalled cycle.
  sfcs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== rtl/core/sfcs_front.sv =====
module sfcs_front import sfcs_pkg::*; #(
  parameter int SECTOR_MASK  = 4095,
  parameter int ADDRESS_BITS = 24
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  input  logic  q_full,
  output logic  push,
  output job_t  push_job
);

  localparam int AB = ADDRESS_BITS;
  localparam int OW = $clog2(PAGE_BYTES);
  localparam int PW = $clog2(PAGE_BYTES + 1);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_ID    = 3'd1;
  localparam logic [2:0] PH_READ  = 3'd2;
  localparam logic [2:0] PH_WDATA = 3'd3;
  localparam logic [2:0] PH_DRAIN = 3'd4;
  localparam logic [2:0] PH_POLL  = 3'd5;

  localparam logic [AB-1:0] SECTOR_KEEP = ~AB'(SECTOR_MASK);

  logic [2:0]       phase, phase_next;
  logic [2:0]       active_command, active_command_next;
  logic [AB-1:0]    addr, addr_next;
  logic [LEN_W-1:0] remaining, remaining_next;
  logic [PW-1:0]    page_left, page_left_next;
  logic [2:0]       due, due_next;
  logic [23:0]      ident, ident_next;

  logic             accept;
  logic [AB-1:0]    req_addr;
  logic [AB-1:0]    sp_addr;
  logic [LEN_W-1:0] sp_len;
  logic [OW-1:0]    sp_off;
  logic [PW-1:0]    sp_room;
  logic [PW-1:0]    sp_chunk;
  logic [2:0]       due_base;
  logic [3:0]       due_sum;
  logic             gen;
  job_t             job;

  // Number of bytes a job sends to the flash.
  function automatic logic [2:0] tx_count(input job_t j);
    logic [2:0] n;
    case (j.kind)
      K_ID_REQ:    n = 3'd4;
      K_READ_HDR:  n = j.flag_a ? 3'd4 : 3'd5;
      K_PAGE:      n = 3'd5;
      K_ERASE:     n = 3'd5;
      K_POLL:      n = 3'd2;
      K_WBYTE:     n = 3'd1;
      K_READ_DATA: n = j.flag_a ? 3'd0 : 3'd1;
      default:     n = 3'd0;
    endcase
    return n;
  endfunction

  assign item_stall = q_full;
  assign accept     = item_valid && !item_stall;
  assign req_addr   = item.address[AB-1:0];

  // A page program starts either from a fresh request or after a poll.
  assign sp_addr  = (phase == PH_IDLE) ? req_addr : addr;
  assign sp_len   = (phase == PH_IDLE) ? item.length : remaining;
  assign sp_off   = sp_addr[OW-1:0];
  assign sp_room  = PW'(PAGE_BYTES) - PW'(sp_off);
  assign sp_chunk = (LEN_W'(sp_room) > sp_len) ? sp_len[PW-1:0] : sp_room;

  always_comb begin
    phase_next          = phase;
    active_command_next = active_command;
    addr_next           = addr;
    remaining_next      = remaining;
    page_left_next      = page_left;
    ident_next          = ident;
    due_base            = due;
    gen                 = 1'b0;
    job                 = '0;

    case (item.op)
      OP_REQUEST: begin
        if (phase == PH_IDLE) begin
          active_command_next = item.command;
          addr_next           = req_addr;
          remaining_next      = item.length;
          gen                 = 1'b1;
          case (item.command)
            CMD_IDENT: begin
              ident_next = '0;
              job.kind   = K_ID_REQ;
              phase_next = PH_ID;
            end
            CMD_FETCH: begin
              job.kind   = K_READ_HDR;
              job.value  = ADDR_W'(req_addr);
              job.flag_a = (item.length == '0);
              job.flag_b = (item.length == LEN_W'(1));
              phase_next = PH_READ;
            end
            CMD_WRITE: begin
              if (item.length == '0) begin
                job.kind = K_DONE;
              end else begin
                job.kind       = K_PAGE;
                job.value      = ADDR_W'(sp_addr);
                page_left_next = sp_chunk;
                phase_next     = PH_WDATA;
              end
            end
            CMD_ERASE: begin
              addr_next  = req_addr & SECTOR_KEEP;
              job.kind   = K_ERASE;
              job.value  = ADDR_W'(req_addr & SECTOR_KEEP);
              phase_next = PH_DRAIN;
            end
            CMD_WAIT: begin
              job.kind   = K_POLL;
              phase_next = PH_POLL;
            end
            default: begin
              job.kind = K_DONE;
            end
          endcase
        end
      end
      OP_WDATA: begin
        if (phase == PH_WDATA && page_left != '0) begin
          gen            = 1'b1;
          job.kind       = K_WBYTE;
          job.data       = item.data_byte;
          job.flag_a     = (page_left == PW'(1));
          page_left_next = page_left - PW'(1);
          if (remaining != '0) begin
            remaining_next = remaining - LEN_W'(1);
          end
          addr_next = addr + AB'(1);
          if (page_left == PW'(1)) begin
            phase_next = PH_DRAIN;
          end
        end
      end
      OP_RX: begin
        if (due != '0) begin
          due_base = due - 3'd1;
          if (phase == PH_ID) begin
            ident_next = {ident[15:0], item.data_byte};
          end
          if (due == 3'd1) begin
            case (phase)
              PH_ID: begin
                gen        = 1'b1;
                job.kind   = K_ID_RES;
                job.value  = {ident[15:0], item.data_byte};
                phase_next = PH_IDLE;
              end
              PH_READ: begin
                gen = 1'b1;
                if (remaining == '0) begin
                  job.kind   = K_DONE;
                  phase_next = PH_IDLE;
                end else begin
                  remaining_next = remaining - LEN_W'(1);
                  job.kind       = K_READ_DATA;
                  job.data       = item.data_byte;
                  job.flag_a     = (remaining == LEN_W'(1));
                  job.flag_b     = (remaining == LEN_W'(2));
                  if (remaining == LEN_W'(1)) begin
                    phase_next = PH_IDLE;
                  end
                end
              end
              PH_DRAIN: begin
                gen        = 1'b1;
                job.kind   = K_POLL;
                phase_next = PH_POLL;
              end
              PH_POLL: begin
                gen = 1'b1;
                if (item.data_byte[0]) begin
                  job.kind = K_POLL;
                end else if (active_command == CMD_WRITE && remaining != '0) begin
                  job.kind       = K_PAGE;
                  job.value      = ADDR_W'(sp_addr);
                  page_left_next = sp_chunk;
                  phase_next     = PH_WDATA;
                end else begin
                  job.kind   = K_DONE;
                  phase_next = PH_IDLE;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase

    // Bytes in flight: every sent byte owes one received byte, capped at seven.
    due_sum  = {1'b0, due_base} + (gen ? {1'b0, tx_count(job)} : 4'd0);
    due_next = (due_sum > 4'd7) ? 3'd7 : due_sum[2:0];
  end

  assign push     = accept && gen;
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      active_command <= '0;
      addr           <= '0;
      remaining      <= '0;
      page_left      <= '0;
      due            <= '0;
      ident          <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      active_command <= active_command_next;
      addr           <= addr_next;
      remaining      <= remaining_next;
      page_left      <= page_left_next;
      due            <= due_next;
      ident          <= ident_next;
    end
  end

`ifndef SYNTHESIS
  a_wdata_has_room: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_WDATA) |-> (page_left != '0))
    else $error("page data phase with no bytes left in the page");
`endif

endmodule

// ===== rtl/core/sfcs_queue.sv =====
module sfcs_queue import sfcs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          entries [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("job queue read while empty");
`endif

endmodule

// ===== rtl/core/sfcs_back.sv =====
module sfcs_back import sfcs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  job_t    head,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic [2:0] step;
  logic       load;
  result_t    cur;

  // Result number "s" of a job.
  function automatic result_t expand(input job_t j, input logic [2:0] s);
    result_t r;
    r = '0;
    case (j.kind)
      K_DONE: begin
        r.done_res = 1'b1;
        r.last     = 1'b1;
      end
      K_ID_REQ: begin
        r.tx_valid    = 1'b1;
        r.tx_byte     = (s == 3'd0) ? FL_RDID : FL_DUMMY;
        r.frame_start = (s == 3'd0);
        r.frame_end   = (s == 3'd3);
        r.last        = (s == 3'd3);
      end
      K_READ_HDR: begin
        r.tx_valid = 1'b1;
        case (s)
          3'd0: begin
            r.tx_byte     = FL_READ;
            r.frame_start = 1'b1;
          end
          3'd1: r.tx_byte = j.value[23:16];
          3'd2: r.tx_byte = j.value[15:8];
          3'd3: begin
            r.tx_byte   = j.value[7:0];
            r.frame_end = j.flag_a;
            r.last      = j.flag_a;
          end
          default: begin
            r.tx_byte   = FL_DUMMY;
            r.frame_end = j.flag_b;
            r.last      = 1'b1;
          end
        endcase
      end
      K_PAGE, K_ERASE: begin
        r.tx_valid = 1'b1;
        case (s)
          3'd0: begin
            r.tx_byte     = FL_WREN;
            r.frame_start = 1'b1;
            r.frame_end   = 1'b1;
          end
          3'd1: begin
            r.tx_byte     = (j.kind == K_PAGE) ? FL_PROG : FL_SE;
            r.frame_start = 1'b1;
          end
          3'd2: r.tx_byte = j.value[23:16];
          3'd3: r.tx_byte = j.value[15:8];
          default: begin
            r.tx_byte   = j.value[7:0];
            r.frame_end = (j.kind == K_ERASE);
            r.last      = 1'b1;
          end
        endcase
      end
      K_POLL: begin
        r.tx_valid    = 1'b1;
        r.tx_byte     = (s == 3'd0) ? FL_RDSR : FL_DUMMY;
        r.frame_start = (s == 3'd0);
        r.frame_end   = (s != 3'd0);
        r.last        = (s != 3'd0);
      end
      K_WBYTE: begin
        r.tx_valid  = 1'b1;
        r.tx_byte   = j.data;
        r.frame_end = j.flag_a;
        r.last      = 1'b1;
      end
      K_ID_RES: begin
        r.id_valid       = 1'b1;
        r.flash_identity = j.value;
        r.done_res       = 1'b1;
        r.last           = 1'b1;
      end
      K_READ_DATA: begin
        if (s == 3'd0) begin
          r.host_valid = 1'b1;
          r.host_byte  = j.data;
          r.done_res   = j.flag_a;
          r.last       = j.flag_a;
        end else begin
          r.tx_valid  = 1'b1;
          r.tx_byte   = FL_DUMMY;
          r.frame_end = j.flag_b;
          r.last      = 1'b1;
        end
      end
      default: begin
        r.last = 1'b1;
      end
    endcase
    return r;
  endfunction

  assign load = !result_valid || !result_stall;
  assign cur  = expand(head, step);
  assign pop  = load && !q_empty && cur.last;

  always_ff @(posedge clk) begin
    if (load) begin
      result <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      step         <= '0;
    end else if (load) begin
      result_valid <= !q_empty;
      if (!q_empty) begin
        step <= cur.last ? 3'd0 : step + 3'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> (result_valid && result.last && step == 3'd0))
    else $error("job retired without its closing result");
`endif

endmodule

// ===== dv/spi_flash_command_sequencer_test.sv =====
`timescale 1ns / 1ps

module spi_flash_command_sequencer_test import sfcs_pkg::*;;

  // The block runs with its default geometry; the predictor uses the same values.
  localparam int SECTOR_MASK  = 4095;
  localparam int ADDRESS_BITS = 24;

  localparam logic [ADDR_W-1:0] ADDR_MASK        = ADDR_W'((1 << ADDRESS_BITS) - 1);
  localparam logic [ADDR_W-1:0] SECTOR_BASE_MASK = ~ADDR_W'(SECTOR_MASK);

  // Codes that the package leaves unnamed because the block treats them as
  // unknown.
  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam int MAX_RESULTS    = 6;
  localparam int MAX_REPORTS    = 10;
  localparam int SETTLE_CYCLES  = 20;
  localparam int RANDOM_PER_MIX = 30;
  localparam int NOISE_PCT      = 12;
  localparam int BUSY_PCT       = 30;

  // Where the predictor stands within the current host request.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_ID,
    SEQ_READ,
    SEQ_WDATA,
    SEQ_DRAIN,
    SEQ_POLL
  } link_phase_e;

  // One row of the directed stimulus. Where checked_here is set, the row
  // carries its own expected result and that result replaces the prediction.
  typedef struct packed {
    item_t   stim;
    logic    checked_here;
    result_t want;
  } plan_row_t;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  item_t   item         = '0;
  logic    result_stall = 1'b0;
  logic    item_stall;
  logic    result_valid;
  result_t result;

  // Predictor state, mirroring what the sequencer keeps between transactions.
  link_phase_e       link_phase = SEQ_IDLE;
  logic [2:0]        cur_cmd    = '0;
  logic [ADDR_W-1:0] cur_addr   = '0;
  logic [LEN_W-1:0]  bytes_left = '0;
  int                page_left  = 0;
  int                bytes_due  = 0;
  logic [ADDR_W-1:0] id_shift   = '0;

  result_t   step_results[$];
  result_t   pending_link_results[$];
  plan_row_t plan_rows[$];

  int gap_pct         = 0;
  int stall_pct       = 0;
  int mismatch_count  = 0;
  int results_checked = 0;
  int directed_count  = 0;
  int random_count    = 0;

  result_t want_r;
  string   diff;

  spi_flash_command_sequencer #(
    .SECTOR_MASK (SECTOR_MASK),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor. Each accepted transaction is run through predict_flash_step,
  // which updates the state above and leaves the results it causes in
  // step_results, the final one marked last.
  // ---------------------------------------------------------------------------

  function automatic void emit_result(logic txv, logic [7:0] txb, logic fs, logic fe,
                                      logic hv, logic [7:0] hb, logic idv,
                                      logic [ADDR_W-1:0] id, logic done);
    result_t r;
    r.tx_valid       = txv;
    r.tx_byte        = txb;
    r.frame_start    = fs;
    r.frame_end      = fe;
    r.host_valid     = hv;
    r.host_byte      = hb;
    r.id_valid       = idv;
    r.flash_identity = id;
    r.done_res       = done;
    r.last           = 1'b0;
    if (step_results.size() < MAX_RESULTS) step_results.push_back(r);
  endfunction

  function automatic void emit_done();
    emit_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, '0, 1'b1);
  endfunction

  // Every byte sent owes one received byte; the count of those saturates at 7.
  function automatic void send_link_byte(logic [7:0] b, logic fs, logic fe);
    emit_result(1'b1, b, fs, fe, 1'b0, 8'h00, 1'b0, '0, 1'b0);
    if (bytes_due < 7) bytes_due++;
  endfunction

  function automatic void send_address(logic [ADDR_W-1:0] a, logic end_frame);
    send_link_byte(a[23:16], 1'b0, 1'b0);
    send_link_byte(a[15:8], 1'b0, 1'b0);
    send_link_byte(a[7:0], 1'b0, end_frame);
  endfunction

  function automatic void start_status_poll();
    send_link_byte(FL_RDSR, 1'b1, 1'b0);
    send_link_byte(FL_DUMMY, 1'b0, 1'b1);
    link_phase = SEQ_POLL;
  endfunction

  // A page program covers the bytes up to the next page edge or the end of
  // the request, whichever comes first.
  function automatic void open_page();
    int chunk;
    chunk = PAGE_BYTES - (cur_addr % PAGE_BYTES);
    if (chunk > bytes_left) chunk = bytes_left;
    page_left = chunk;
    send_link_byte(FL_WREN, 1'b1, 1'b1);
    send_link_byte(FL_PROG, 1'b1, 1'b0);
    send_address(cur_addr, 1'b0);
    link_phase = SEQ_WDATA;
  endfunction

  // Returns 0 when the block ignores the transaction outright.
  function automatic logic predict_flash_step(item_t it);
    result_t tail;
    step_results.delete();
    case (it.op)
      OP_REQUEST: begin
        if (link_phase != SEQ_IDLE) return 1'b0;
        cur_cmd    = it.command;
        cur_addr   = it.address & ADDR_MASK;
        bytes_left = it.length;
        case (it.command)
          CMD_IDENT: begin
            id_shift = '0;
            send_link_byte(FL_RDID, 1'b1, 1'b0);
            send_link_byte(FL_DUMMY, 1'b0, 1'b0);
            send_link_byte(FL_DUMMY, 1'b0, 1'b0);
            send_link_byte(FL_DUMMY, 1'b0, 1'b1);
            link_phase = SEQ_ID;
          end
          CMD_FETCH: begin
            send_link_byte(FL_READ, 1'b1, 1'b0);
            send_address(cur_addr, bytes_left == 0);
            if (bytes_left != 0) send_link_byte(FL_DUMMY, 1'b0, bytes_left == 1);
            link_phase = SEQ_READ;
          end
          CMD_WRITE: begin
            if (bytes_left == 0) emit_done();
            else open_page();
          end
          CMD_ERASE: begin
            cur_addr = cur_addr & SECTOR_BASE_MASK;
            send_link_byte(FL_WREN, 1'b1, 1'b1);
            send_link_byte(FL_SE, 1'b1, 1'b0);
            send_address(cur_addr, 1'b1);
            link_phase = SEQ_DRAIN;
          end
          CMD_WAIT: start_status_poll();
          default: emit_done();
        endcase
      end
      OP_WDATA: begin
        if (link_phase != SEQ_WDATA || page_left == 0) return 1'b0;
        send_link_byte(it.data_byte, 1'b0, page_left == 1);
        page_left--;
        if (bytes_left != 0) bytes_left--;
        cur_addr = (cur_addr + ADDR_W'(1)) & ADDR_MASK;
        if (page_left == 0) link_phase = SEQ_DRAIN;
      end
      OP_RX: begin
        if (bytes_due == 0) return 1'b0;
        bytes_due--;
        if (link_phase == SEQ_ID) id_shift = {id_shift[15:0], it.data_byte};
        // Only the byte that completes the outstanding count moves things on.
        if (bytes_due == 0) begin
          case (link_phase)
            SEQ_ID: begin
              emit_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, id_shift, 1'b1);
              link_phase = SEQ_IDLE;
            end
            SEQ_READ: begin
              if (bytes_left == 0) begin
                emit_done();
                link_phase = SEQ_IDLE;
              end else begin
                bytes_left--;
                emit_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, it.data_byte, 1'b0, '0,
                            bytes_left == 0);
                if (bytes_left != 0) send_link_byte(FL_DUMMY, 1'b0, bytes_left == 1);
                else link_phase = SEQ_IDLE;
              end
            end
            SEQ_DRAIN: start_status_poll();
            SEQ_POLL: begin
              if (it.data_byte[0]) begin
                start_status_poll();
              end else if (cur_cmd == CMD_WRITE && bytes_left != 0) begin
                open_page();
              end else begin
                emit_done();
                link_phase = SEQ_IDLE;
              end
            end
            default: ;
          endcase
        end
      end
      default: return 1'b0;
    endcase
    if (step_results.size() > 0) begin
      tail = step_results.pop_back();
      tail.last = 1'b1;
      step_results.push_back(tail);
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // A result that stands alone: a done mark, optionally with the identity.
  function automatic result_t lone_result(logic idv, logic [ADDR_W-1:0] id);
    result_t r;
    r = '0;
    r.id_valid       = idv;
    r.flash_identity = id;
    r.done_res       = 1'b1;
    r.last           = 1'b1;
    return r;
  endfunction

  function automatic void add_row(logic [1:0] op, logic [2:0] cmd, logic [ADDR_W-1:0] a,
                                  logic [LEN_W-1:0] len, logic [7:0] b, logic checked_here,
                                  result_t want);
    plan_row_t row;
    row.stim.op        = op;
    row.stim.command   = cmd;
    row.stim.address   = a;
    row.stim.length    = len;
    row.stim.data_byte = b;
    row.checked_here   = checked_here;
    row.want           = want;
    plan_rows.push_back(row);
  endfunction

  // The random part plays the flash side: it answers every byte in flight,
  // feeds page data while a program frame is open, and reports busy on some
  // status reads. A share of transactions is plain noise of any kind. All
  // fields carry random content even where the block ignores them.
  function automatic item_t next_flash_item();
    item_t it;
    int    pick;
    it.op        = OP_RX;
    it.command   = 3'($urandom_range(7));
    it.address   = ADDR_W'($urandom);
    it.length    = LEN_W'($urandom);
    it.data_byte = 8'($urandom);
    if ($urandom_range(99) < NOISE_PCT) begin
      it.op = 2'($urandom_range(3));
      return it;
    end
    if (link_phase == SEQ_IDLE) begin
      it.op = OP_REQUEST;
      pick  = $urandom_range(9);
      case (pick)
        0:       it.command = CMD_IDENT;
        1, 2, 3: it.command = CMD_FETCH;
        4, 5, 6: it.command = CMD_WRITE;
        7:       it.command = CMD_ERASE;
        8:       it.command = CMD_WAIT;
        default: it.command = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
      endcase
      // Addresses near the top make writes cross a page edge and wrap.
      if ($urandom_range(3) == 0) it.address = ADDR_MASK - ADDR_W'($urandom_range(15));
      if (it.command == CMD_FETCH || it.command == CMD_WRITE) begin
        if ($urandom_range(9) == 0) it.length = '0;
        else if ($urandom_range(9) == 0) it.length = LEN_W'($urandom_range(40, 13));
        else it.length = LEN_W'($urandom_range(12, 1));
      end
      return it;
    end
    // Page data goes in between answers; with many bytes in flight the flash
    // usually answers first, but sometimes the due count is pushed to saturate.
    if (link_phase == SEQ_WDATA && page_left != 0 &&
        (bytes_due == 0 || $urandom_range(99) >= (bytes_due >= 6 ? 80 : 30))) begin
      it.op = OP_WDATA;
      return it;
    end
    if (bytes_due == 0) begin
      it.op = OP_WDATA;
      return it;
    end
    if (link_phase == SEQ_POLL && bytes_due == 1) it.data_byte[0] = ($urandom_range(99) < BUSY_PCT);
    return it;
  endfunction

  // Drives one transaction at the falling edge, holds it until accepted at a
  // rising edge, and then books the results it is expected to cause.
  task automatic send_item(input item_t it, input logic checked_here, input result_t want,
                           output logic taken);
    int gap;
    gap = 0;
    @(negedge clk);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    taken = predict_flash_step(it);
    if (checked_here) pending_link_results.push_back(want);
    else foreach (step_results[k]) pending_link_results.push_back(step_results[k]);
  endtask

  // The result side stalls at random; the rate is set per mix below.
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result is matched against the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_checked++;
      if (pending_link_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("[%0t] result with nothing expected: got %h", $realtime, result);
        end
      end else begin
        want_r = pending_link_results.pop_front();
        diff = "";
        if (result.tx_valid !== want_r.tx_valid) diff = {diff, " tx_valid"};
        if (result.tx_byte !== want_r.tx_byte) diff = {diff, " tx_byte"};
        if (result.frame_start !== want_r.frame_start) diff = {diff, " frame_start"};
        if (result.frame_end !== want_r.frame_end) diff = {diff, " frame_end"};
        if (result.host_valid !== want_r.host_valid) diff = {diff, " host_valid"};
        if (result.host_byte !== want_r.host_byte) diff = {diff, " host_byte"};
        if (result.id_valid !== want_r.id_valid) diff = {diff, " id_valid"};
        if (result.flash_identity !== want_r.flash_identity) diff = {diff, " flash_identity"};
        if (result.done_res !== want_r.done_res) diff = {diff, " done_res"};
        if (result.last !== want_r.last) diff = {diff, " last"};
        if (diff != "") begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] result mismatch in%s: expected %h got %h", $realtime, diff,
                     want_r, result);
          end
        end
      end
    end
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    item_t stim;
    logic  taken;
    int    counted;

    // Directed part. Special cases first: a received byte with nothing due,
    // page data outside a program frame and an unknown op are all ignored.
    add_row(OP_RX, CMD_IDENT, 24'h000000, 25'h0000000, 8'hA5, 1'b0, '0);
    add_row(OP_WDATA, CMD_WRITE, 24'h000000, 25'h0000000, 8'h5A, 1'b0, '0);
    add_row(OP_UNUSED, CMD_SPARE_HI, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF, 1'b0, '0);
    // Unknown commands and an empty write answer with a lone done.
    add_row(OP_REQUEST, CMD_SPARE_LO, 24'h000000, 25'h0000000, 8'h00, 1'b1,
            lone_result(1'b0, '0));
    add_row(OP_REQUEST, CMD_SPARE_HI, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF, 1'b1,
            lone_result(1'b0, '0));
    add_row(OP_REQUEST, CMD_WRITE, 24'hFFFFFF, 25'h0000000, 8'h00, 1'b1,
            lone_result(1'b0, '0));
    // Identity: the three bytes after the command byte pack high to low.
    add_row(OP_REQUEST, CMD_IDENT, 24'h123456, 25'h1000000, 8'h00, 1'b0, '0);
    add_row(OP_RX, CMD_IDENT, 24'h000000, 25'h0000000, 8'h00, 1'b0, '0);
    add_row(OP_RX, CMD_IDENT, 24'h000000, 25'h0000000, 8'hEF, 1'b0, '0);
    add_row(OP_RX, CMD_IDENT, 24'h000000, 25'h0000000, 8'h40, 1'b0, '0);
    add_row(OP_RX, CMD_IDENT, 24'h000000, 25'h0000000, 8'h18, 1'b1,
            lone_result(1'b1, 24'hEF4018));
    // Empty read at the top address: header only, and a request arriving
    // meanwhile is dropped. Done comes with the fourth received byte.
    add_row(OP_REQUEST, CMD_FETCH, 24'hFFFFFF, 25'h0000000, 8'h00, 1'b0, '0);
    add_row(OP_REQUEST, CMD_ERASE, 24'h000000, 25'h0000001, 8'h00, 1'b0, '0);
    add_row(OP_RX, CMD_FETCH, 24'h000000, 25'h0000000, 8'hFF, 1'b0, '0);
    add_row(OP_RX, CMD_FETCH, 24'h000000, 25'h0000000, 8'h00, 1'b0, '0);
    add_row(OP_RX, CMD_FETCH, 24'h000000, 25'h0000000, 8'h3C, 1'b0, '0);
    add_row(OP_RX, CMD_FETCH, 24'h000000, 25'h0000000, 8'hC3, 1'b1, lone_result(1'b0, '0));
    // Erase at the top address drops to the sector base, then the status
    // is polled once busy and once clear.
    add_row(OP_REQUEST, CMD_ERASE, 24'hFFFFFF, 25'h1000000, 8'h00, 1'b0, '0);
    add_row(OP_RX, CMD_ERASE, 24'h000000, 25'h0000000, 8'h11, 1'b0, '0);
    add_row(OP_RX, CMD_ERASE, 24'h000000, 25'h0000000, 8'h22, 1'b0, '0);
    add_row(OP_RX, CMD_ERASE, 24'h000000, 25'h0000000, 8'h33, 1'b0, '0);
    add_row(OP_RX, CMD_ERASE, 24'h000000, 25'h0000000, 8'h44, 1'b0, '0);
    add_row(OP_RX, CMD_ERASE, 24'h000000, 25'h0000000, 8'h55, 1'b0, '0);
    add_row(OP_RX, CMD_ERASE, 24'h000000, 25'h0000000, 8'hFF, 1'b0, '0);
    add_row(OP_RX, CMD_ERASE, 24'h000000, 25'h0000000, 8'h01, 1'b0, '0);
    add_row(OP_RX, CMD_ERASE, 24'h000000, 25'h0000000, 8'h00, 1'b0, '0);
    add_row(OP_RX, CMD_ERASE, 24'h000000, 25'h0000000, 8'hFE, 1'b1, lone_result(1'b0, '0));

    // Synchronous reset, released at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan_rows[i]) begin
      send_item(plan_rows[i].stim, plan_rows[i].checked_here, plan_rows[i].want, taken);
      directed_count++;
    end

    // Random part in four mixes: no idling, sender idle most cycles,
    // receiver stalling most cycles, and both at a moderate rate. Between
    // mixes the sender holds off until every booked result has come back.
    for (int mix = 0; mix < 4; mix++) begin
      case (mix)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 71;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 71;
        end
        default: begin
          gap_pct   = 36;
          stall_pct = 36;
        end
      endcase
      @(negedge clk);
      item_valid <= 1'b0;
      while (pending_link_results.size() != 0) @(posedge clk);
      repeat (8) @(posedge clk);
      counted = 0;
      while (counted < RANDOM_PER_MIX) begin
        stim = next_flash_item();
        send_item(stim, 1'b0, '0, taken);
        if (taken) begin
          counted++;
          random_count++;
        end
      end
    end

    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_link_results.size() != 0) @(posedge clk);
    // The settle period catches any stray result after the last expected one.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d directed and %0d random transactions; %0d results checked.",
             directed_count, random_count, results_checked);
    $display("Four idle/stall mixes run; %0d mismatches seen.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== spi_flash_command_sequencer.f =====
rtl/core/sfcs_pkg.sv
rtl/core/sfcs_front.sv
rtl/core/sfcs_queue.sv
rtl/core/sfcs_back.sv
rtl/core/spi_flash_command_sequencer.sv
dv/spi_flash_command_sequencer_test.sv
